FILE: rtl/gbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants for the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

   // Two-bit saturating counter values.
   localparam logic [1:0] COUNTER_RESET = 2'd2;
   localparam logic [1:0] COUNTER_TOP   = 2'd3;
   localparam logic [1:0] COUNTER_ZERO  = 2'd0;

   // Configuration register indexes.
   localparam logic [3:0] REG_INDEX_BITS   = 4'd0;
   localparam logic [3:0] REG_HISTORY_BITS = 4'd1;

   // Configuration reset values.
   localparam logic [3:0] INDEX_BITS_RESET   = 4'd12;
   localparam logic [3:0] HISTORY_BITS_RESET = 4'd8;

   // One prediction result.
   typedef struct packed {
      logic mispredicted;
      logic predicted_taken;
   } gbp_result_type;

endpackage

FILE: rtl/gshare_branch_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor_unit
// Gshare predictor with 2-bit saturating counters, updated by resolved branches.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Fields
//  --------+-----------+---------------------------------------------------
//  req_    | in        | tdata: branch_address[31:0], outcome_taken[32]
//  rsp_    | out       | tdata: predicted_taken[0], mispredicted[1]
//  csr_    | in        | index 0 = index_bits, 1 = history_bits, wdata 4 bits
//
// One transaction per cycle is sustained while no clear runs and the queue has
// room. A result reaches rsp_ via the stage-1 registers, loaded as the counter
// memory is read, then the result queue; the updated count is written back as
// the result is queued. After reset all 2**INDEX_BITS_MAX entries (4096 by default)
// are cleared one per cycle, with req_tready low; csr_ writes are taken at all times.
// A three-entry result queue keeps requests flowing through short stalls.
//
module gshare_branch_predictor_unit #(
   parameter int INDEX_BITS_MAX = 12
) (
   input  logic        clock,
   input  logic        reset,
   // Request: [31:0] branch_address, [32] outcome_taken, [39:33] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // Response: [0] predicted_taken, [1] mispredicted, [7:2] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int IW    = INDEX_BITS_MAX;
   localparam int CNT_W = $clog2(INDEX_BITS_MAX + 1);
   localparam int BW    = (CNT_W > 4) ? CNT_W : 4;

   localparam logic [1:0] QUEUE_LAST = 2'd2;
   localparam logic [1:0] QUEUE_FULL = 2'd3;

   // Configuration registers.
   logic [3:0] index_bits_ff, index_bits_in;
   logic [3:0] history_bits_ff, history_bits_in;

   // Global history, kept at the full index width.
   logic [IW-1:0] history_ff, history_in;

   logic          req_accept;
   logic          req_taken;
   logic [BW-1:0] ib_eff;
   logic [BW-1:0] hb_eff;
   logic [BW-1:0] hist_shift;
   logic [IW-1:0] imask;
   logic [IW-1:0] hmask;
   logic [IW-1:0] hist_m;
   logic [IW-1:0] hist_dn;
   logic [IW-1:0] lookup_index;

   logic                    store_busy;
   logic                    result_valid;
   gbp_pkg::gbp_result_type result;

   // Result queue.
   gbp_pkg::gbp_result_type q_data_ff [3];
   logic [1:0] q_wr_ptr_ff, q_wr_ptr_in;
   logic [1:0] q_rd_ptr_ff, q_rd_ptr_in;
   logic [1:0] q_count_ff, q_count_in;
   logic       q_push;
   logic       q_pop;
   logic [2:0] q_reserved;

   // ------------------------------------------------------------------
   // Configuration. Writes to an index beyond the register list are
   // dropped; the channel is always ready.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      index_bits_in   = index_bits_ff;
      history_bits_in = history_bits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gbp_pkg::REG_INDEX_BITS:   index_bits_in   = csr_wdata;
            gbp_pkg::REG_HISTORY_BITS: history_bits_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Index formation. Both lengths are clamped: the index width to
   // 1..INDEX_BITS_MAX, the history length to the index width.
   // ------------------------------------------------------------------
   always_comb begin
      ib_eff = BW'(index_bits_ff);
      if (ib_eff == '0) begin
         ib_eff = BW'(1);
      end else if (ib_eff > BW'(INDEX_BITS_MAX)) begin
         ib_eff = BW'(INDEX_BITS_MAX);
      end
      hb_eff = BW'(history_bits_ff);
      if (hb_eff > ib_eff) begin
         hb_eff = ib_eff;
      end
      hist_shift = ib_eff - hb_eff;
   end

   always_comb begin
      for (int i = 0; i < IW; i++) begin
         imask[i] = (BW'(i) < ib_eff);
         hmask[i] = (BW'(i) < hb_eff);
      end
   end

   // Stale history bits above the current length never reach the index.
   assign hist_m       = history_ff & hmask;
   assign lookup_index = (req_tdata[IW+1:2] ^ (hist_m << hist_shift)) & imask;
   assign req_taken    = req_tdata[32];

   // The outcome enters at the top of the history and the oldest bit drops
   // out; a zero history length leaves the register untouched.
   assign hist_dn = hist_m >> 1;

   always_comb begin
      history_in = history_ff;
      if (req_accept && (hb_eff != '0)) begin
         for (int i = 0; i < IW; i++) begin
            if (BW'(i) == hb_eff - BW'(1)) begin
               history_in[i] = req_taken;
            end else begin
               history_in[i] = hist_dn[i] & hmask[i];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Counter memory.
   // ------------------------------------------------------------------
   gbp_counter_store #(
      .INDEX_BITS_MAX (INDEX_BITS_MAX)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .lookup_valid (req_accept),
      .lookup_index (lookup_index),
      .lookup_taken (req_taken),
      .clear_busy   (store_busy),
      .result_valid (result_valid),
      .result       (result)
   );

   // ------------------------------------------------------------------
   // Result queue. A request is taken only when the queue has room for
   // it in addition to every result already in flight.
   // ------------------------------------------------------------------
   assign q_reserved = 3'(q_count_ff) + 3'(result_valid);
   assign req_tready = !store_busy && (q_reserved < 3'(QUEUE_FULL));
   assign req_accept = req_tvalid && req_tready;

   assign q_push = result_valid;
   assign q_pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      q_wr_ptr_in = q_wr_ptr_ff;
      q_rd_ptr_in = q_rd_ptr_ff;
      if (q_push) begin
         q_wr_ptr_in = (q_wr_ptr_ff == QUEUE_LAST) ? 2'd0 : q_wr_ptr_ff + 2'd1;
      end
      if (q_pop) begin
         q_rd_ptr_in = (q_rd_ptr_ff == QUEUE_LAST) ? 2'd0 : q_rd_ptr_ff + 2'd1;
      end
      case ({q_push, q_pop})
         2'b10:   q_count_in = q_count_ff + 2'd1;
         2'b01:   q_count_in = q_count_ff - 2'd1;
         default: q_count_in = q_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff   <= gbp_pkg::INDEX_BITS_RESET;
         history_bits_ff <= gbp_pkg::HISTORY_BITS_RESET;
         history_ff      <= '0;
         q_wr_ptr_ff     <= '0;
         q_rd_ptr_ff     <= '0;
         q_count_ff      <= '0;
      end else begin
         index_bits_ff   <= index_bits_in;
         history_bits_ff <= history_bits_in;
         history_ff      <= history_in;
         q_wr_ptr_ff     <= q_wr_ptr_in;
         q_rd_ptr_ff     <= q_rd_ptr_in;
         q_count_ff      <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_data_ff[q_wr_ptr_ff] <= result;
      end
   end

   assign rsp_tvalid = (q_count_ff != 2'd0);
   assign rsp_tdata  = {6'd0, q_data_ff[q_rd_ptr_ff]};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // A result never arrives at a full queue.
   assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (q_count_ff != QUEUE_FULL))
      else $error("result pushed into a full queue");

   // Queued plus in-flight results never exceed the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      q_reserved <= 3'(QUEUE_FULL))
      else $error("result queue overcommitted");

   // Every accepted request yields a counter result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> result_valid)
      else $error("accepted request produced no result");

endmodule

FILE: rtl/gbp_counter_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_counter_store
// Counter memory with read-modify-write, forwarding and a post-reset clear.
// ----------------------------------------------------------------------------
module gbp_counter_store #(
   parameter int INDEX_BITS_MAX = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           lookup_valid,
   input  logic [INDEX_BITS_MAX-1:0]      lookup_index,
   input  logic                           lookup_taken,
   output logic                           clear_busy,
   output logic                           result_valid,
   output gbp_pkg::gbp_result_type        result
);

   localparam int DEPTH = 1 << INDEX_BITS_MAX;

   logic [1:0] mem [DEPTH];

   logic                      clr_active_ff, clr_active_in;
   logic [INDEX_BITS_MAX-1:0] clr_addr_ff, clr_addr_in;

   logic                      s1_valid_ff;
   logic [INDEX_BITS_MAX-1:0] s1_index_ff;
   logic                      s1_taken_ff;
   logic [1:0]                rd_data_ff;
   logic                      fwd_hit_ff, fwd_hit_in;
   logic [1:0]                fwd_data_ff;

   logic [1:0] ctr_cur;
   logic [1:0] ctr_new;

   // The clear sweep writes every entry once, one per cycle.
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= lookup_valid;
         fwd_hit_ff    <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= lookup_index;
      s1_taken_ff <= lookup_taken;
      fwd_data_ff <= ctr_new;
   end

   // The previous item writes its entry on the same edge that this item
   // reads it, so the memory still returns the old count; forward instead.
   assign fwd_hit_in = s1_valid_ff && lookup_valid && (s1_index_ff == lookup_index);

   always_comb begin
      ctr_cur = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      ctr_new = ctr_cur;
      if (s1_taken_ff) begin
         if (ctr_cur != gbp_pkg::COUNTER_TOP) begin
            ctr_new = ctr_cur + 2'd1;
         end
      end else begin
         if (ctr_cur != gbp_pkg::COUNTER_ZERO) begin
            ctr_new = ctr_cur - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[lookup_index];
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= gbp_pkg::COUNTER_RESET;
      end else if (s1_valid_ff) begin
         mem[s1_index_ff] <= ctr_new;
      end
   end

   assign clear_busy             = clr_active_ff;
   assign result_valid           = s1_valid_ff;
   assign result.predicted_taken = ctr_cur[1];
   assign result.mispredicted    = ctr_cur[1] ^ s1_taken_ff;

endmodule
